/* design/ucfp_pkg.sv */
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared constants and types for the command frame parser: frame marker
// bytes, parser states and the status word passed from the frame tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ucfp_pkg;

	// frame marker bytes
	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] ID_BYTE   = 8'h02;
	localparam logic [7:0] LEN_BYTE  = 8'h03;
	localparam logic [7:0] END_BYTE  = 8'hAA;

	// speed divided by ten as (x * DIV10_MULT) >> DIV10_SHIFT, exact for 16-bit x
	localparam int unsigned DIV10_SHIFT = 19;
	localparam logic [15:0] DIV10_MULT  = 16'd52429;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned QUOT_W  = 13;

	// parser position, one-hot
	typedef enum logic [7:0] {
		ST_SYNC  = 8'b0000_0001,
		ST_ID    = 8'b0000_0010,
		ST_LEN   = 8'b0000_0100,
		ST_CMD   = 8'b0000_1000,
		ST_SPDH  = 8'b0001_0000,
		ST_SPDL  = 8'b0010_0000,
		ST_CSUM  = 8'b0100_0000,
		ST_END   = 8'b1000_0000
	} state_t;

	// status of the word currently offered to the frame tracker
	typedef struct packed {
		logic               done;     // this word completes a good frame
		logic [7:0]         command;  // command byte of the frame
		logic [SPEED_W-1:0] speed;    // raw big-endian speed field
	} frame_t;

endpackage

`default_nettype wire

/* design/ucfp_frame_fsm.sv */
// ----------------------------------------------------------------------------
// ucfp_frame_fsm
// Frame tracker: walks the eight positions of a command frame, keeps the
// running checksum and holds the command and speed bytes of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfp_frame_fsm import ucfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output frame_t          frame
);

	state_t     state_q, state_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] command_q;
	logic [7:0] speed_hi_q;
	logic [7:0] speed_lo_q;

	// next position and checksum
	always_comb begin
		state_d = state_q;
		sum_d   = sum_q;
		case (state_q)
			ST_SYNC: begin
				sum_d   = rx_byte;
				state_d = (rx_byte == SYNC_BYTE) ? ST_ID : ST_SYNC;
			end
			ST_ID: begin
				sum_d   = rx_byte;
				state_d = (rx_byte == ID_BYTE) ? ST_LEN : ST_SYNC;
				if (rx_byte != ID_BYTE) begin
					sum_d = sum_q;
				end
			end
			ST_LEN: begin
				if (rx_byte == LEN_BYTE) begin
					sum_d   = sum_q + rx_byte;
					state_d = ST_CMD;
				end else begin
					state_d = ST_SYNC;
				end
			end
			ST_CMD: begin
				sum_d   = sum_q + rx_byte;
				state_d = ST_SPDH;
			end
			ST_SPDH: begin
				sum_d   = sum_q + rx_byte;
				state_d = ST_SPDL;
			end
			ST_SPDL: begin
				sum_d   = sum_q + rx_byte;
				state_d = ST_CSUM;
			end
			ST_CSUM: begin
				state_d = (rx_byte == sum_q) ? ST_END : ST_SYNC;
			end
			ST_END: begin
				state_d = ST_SYNC;
			end
			default: begin
				state_d = ST_SYNC;
			end
		endcase
	end

	// state and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SYNC;
			sum_q      <= '0;
			command_q  <= '0;
			speed_hi_q <= '0;
			speed_lo_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			sum_q   <= sum_d;
			if (state_q == ST_CMD) begin
				command_q <= rx_byte;
			end
			if (state_q == ST_SPDH) begin
				speed_hi_q <= rx_byte;
			end
			if (state_q == ST_SPDL) begin
				speed_lo_q <= rx_byte;
			end
		end
	end

	// frame complete on a correct end byte
	assign frame.done    = (state_q == ST_END) && (rx_byte == END_BYTE);
	assign frame.command = command_q;
	assign frame.speed   = {speed_hi_q, speed_lo_q};

endmodule

`default_nettype wire

/* design/ucfp_div10.sv */
// ----------------------------------------------------------------------------
// ucfp_div10
// Divide a 16-bit speed by ten through a reciprocal multiply and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfp_div10 import ucfp_pkg::*; (
	input  wire logic [SPEED_W-1:0] speed,
	output logic [QUOT_W-1:0]       quotient
);

	logic [2*SPEED_W-1:0] product;

	// reciprocal multiply, quotient is the top bits
	assign product  = speed * DIV10_MULT;
	assign quotient = product[DIV10_SHIFT +: QUOT_W];

endmodule

`default_nettype wire

/* design/uart_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// uart_command_frame_parser
// Recognizes sync/id/length/command/speed/checksum/end command frames in a
// byte stream and returns the command byte and the speed divided by ten.
// ----------------------------------------------------------------------------
//
//  channel  signals                              direction  width
//  rx       rx_valid rx_ready rx_byte            in         8
//  cmd      cmd_valid cmd_ready motor_command    out        8 + 13
//           speed_command
//
//  One byte per cycle while no held result stalls an end byte: a byte lands
//  in the input register, the frame tracker and the divide-by-ten multiply
//  work on it combinationally, and a result is in the output register at the
//  edge the end byte leaves the input register.
//  The input register refills in the same cycle it drains.
//  A held result stalls only an end byte; other bytes keep flowing.
//  arst_n clears the parser to waiting for sync and empties both registers.
//
`default_nettype none

module uart_command_frame_parser import ucfp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire logic [7:0]        rx_byte,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output logic [7:0]             motor_command,
	output logic [QUOT_W-1:0]      speed_command
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic [7:0]        command_q;
	logic [QUOT_W-1:0] speed_q;
	logic              out_free;
	logic              advance;
	frame_t            frame;
	logic [QUOT_W-1:0] quotient;

	// handshake control
	assign out_free = !out_valid_q || cmd_ready;
	assign advance  = valid_s1 && (!frame.done || out_free);
	assign rx_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame tracking
	ucfp_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	// speed scaling
	ucfp_div10 u_div10 (
		.speed    (frame.speed),
		.quotient (quotient)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && frame.done;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame.done) begin
			command_q <= frame.command;
			speed_q   <= quotient;
		end
	end

	assign cmd_valid     = out_valid_q;
	assign motor_command = command_q;
	assign speed_command = speed_q;

endmodule

`default_nettype wire

/* design/ucfp_checker.sv */
// ----------------------------------------------------------------------------
// ucfp_checker
// Port-level checks for the command frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfp_checker import ucfp_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rx_valid,
	input wire logic              rx_ready,
	input wire logic [7:0]        rx_byte,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire logic [7:0]        motor_command,
	input wire logic [QUOT_W-1:0] speed_command
);

	// no result while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !cmd_valid)
		else $error("result valid during reset");

	// scaled speed never exceeds 65535 / 10
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> speed_command <= 13'd6553)
		else $error("speed out of range");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> $stable(motor_command) && $stable(speed_command))
		else $error("result changed while stalled");

	// a waiting input word stays offered and unchanged
	a_rx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && !rx_ready |=> rx_valid && $stable(rx_byte))
		else $error("input word dropped or changed while waiting");

endmodule

bind uart_command_frame_parser ucfp_checker u_ucfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx_valid),
	.rx_ready      (rx_ready),
	.rx_byte       (rx_byte),
	.cmd_valid     (cmd_valid),
	.cmd_ready     (cmd_ready),
	.motor_command (motor_command),
	.speed_command (speed_command)
);

`default_nettype wire
